>>> hdl/afws_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and coefficient tables of the A-weighting filter.
// Used by afws_mac, afws_seq and the top level; depends on nothing else.
package afws_pkg;

    localparam int ACC_W    = 64;
    localparam int COEF_W   = 33;
    localparam int LO_BITS  = 24;
    localparam int OPND_W   = LO_BITS + 1;
    localparam int PROD_W   = COEF_W + OPND_W;
    localparam int EXT_W    = PROD_W + LO_BITS + 1;
    localparam int TAP_BITS = 4;
    localparam int MAX_TAPS = 16;
    localparam int TAB_FRAC = 20;

    // Mode code of an item that filters its sample; any other code clears.
    localparam logic [1:0] MODE_FILTER = 2'd0;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Coefficients of the 48 kHz design, round half up at 2^-20.
    localparam int NUM_TAB [MAX_TAPS] = '{
        245681, -491363, -245681, 982726, -245681, -491363, 245681,
        0, 0, 0, 0, 0, 0, 0, 0, 0
    };
    localparam int DEN_TAB [MAX_TAPS] = '{
        1048576, -4312846, 6871484, -5233357, 1872542, -258171, 11771,
        0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_FEED,
        S_FEED_RND,
        S_W0,
        S_OUT,
        S_OUT_RND,
        S_Y,
        S_SQ,
        S_SQ_WAIT,
        S_STATS,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_state              state;
        logic [TAP_BITS-1:0] tap;
        logic                hi;
    } t_seq_ctl;

    typedef struct packed {
        logic issue;
        logic hi;
        logic load;
        logic add;
    } t_mac_ctl;

    // Rescales a table entry to the chosen number of fraction bits.
    function automatic logic signed [COEF_W-1:0] scale_coef(input int raw, input int frac);
        logic signed [ACC_W-1:0] v;
        v = ACC_W'(raw);
        if (frac >= TAB_FRAC) begin
            v = v <<< (frac - TAB_FRAC);
        end else begin
            v = (v + (64'sd1 <<< (TAB_FRAC - frac - 1))) >>> (TAB_FRAC - frac);
        end
        return v[COEF_W-1:0];
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_num(input logic [TAP_BITS-1:0] idx,
                                                           input int frac);
        return scale_coef(NUM_TAB[idx], frac);
    endfunction

    // The feedback sum subtracts, so the denominator is kept negated.
    function automatic logic signed [COEF_W-1:0] coef_den_neg(input logic [TAP_BITS-1:0] idx,
                                                               input int frac);
        return -scale_coef(DEN_TAB[idx], frac);
    endfunction

endpackage

>>> hdl/a_weighting_filter_with_level_stats.sv
`timescale 1ns / 1ps
// Top level of the A-weighting filter with level statistics: delay line,
// statistics registers and output register. Depends on afws_pkg, afws_mac, afws_seq.
//
// Usage
// Each input item on the s_axis channel carries a mode in s_axis_tuser and a
// signed audio sample in s_axis_tdata. Mode 0 filters the sample through the
// sixth-order A-weighting filter (direct form II); mode 1 clears the peak,
// energy and count statistics; modes 2 and 3 clear the delay line as well.
// Every item yields exactly one result item on m_axis: the filtered sample
// (zero for a clearing item) together with the current peak, energy and count.
// All products go through one shared multiplier whose 64-bit saturating
// accumulator is driven by a small sequencer; each tap takes two products,
// because the delay word is split into two halves. A filtering item steps
// through the feedback taps, the output taps, the squaring and the statistics
// update before its result is emitted; a clearing item goes straight to the
// emit step. s_axis_tready is high only while the sequencer is idle, so the
// next item is taken only once the last one has been emitted. The result sits
// in an output register, so a new item is taken while an earlier result still
// waits; if the receiver stalls, the sequencer holds its finished result until
// the output register is free. Reset clears the delay line, the statistics and
// both valid flags.
module a_weighting_filter_with_level_stats #(
    parameter int TAPS           = 7,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // [SAMPLE_BITS-1:0] sample, zero padding above.
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // [1:0] mode.
    input  logic [1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // filtered, peak_level, energy_sum (63 bits), sample_total (32 bits),
    // from the lowest bit up, zero padding above.
    output logic [((2*SAMPLE_BITS+95+7)/8)*8-1:0] m_axis_tdata
);
    import afws_pkg::*;

    localparam int DELAY_BITS = SAMPLE_BITS + 16;
    localparam int DEPTH      = TAPS - 1;
    localparam int DIW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OUT_W      = ((2*SAMPLE_BITS+95+7)/8)*8;
    localparam int PAD_W      = OUT_W - (2*SAMPLE_BITS + 95);
    localparam int HI_W       = DELAY_BITS - LO_BITS;

    localparam logic signed [ACC_W-1:0] W_MAX = (64'sd1 <<< (DELAY_BITS-1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] W_MIN = -W_MAX - 64'sd1;
    localparam logic signed [ACC_W-1:0] Y_MAX = (64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - 64'sd1;
    localparam logic signed [ACC_W-1:0] RND   = 64'sd1 <<< (COEF_FRAC_BITS-1);

    // Stored state.
    logic [DELAY_BITS-1:0]  r_delay [DEPTH];
    logic [DELAY_BITS-1:0]  r_w0;
    logic [SAMPLE_BITS-1:0] r_y;
    logic [SAMPLE_BITS-1:0] r_peak;
    logic [62:0]            r_energy;
    logic [31:0]            r_count;
    logic                   r_out_vld;
    logic [OUT_W-1:0]       r_out_data;

    t_seq_ctl                  w_ctl;
    t_mac_ctl                  w_mac_ctl;
    logic                      w_busy;
    logic                      w_accept;
    logic                      w_clear;
    logic                      w_emit_ok;
    logic signed [SAMPLE_BITS-1:0] w_x;
    logic signed [COEF_W-1:0]  w_coef;
    logic signed [OPND_W-1:0]  w_opnd;
    logic signed [ACC_W-1:0]   w_value;
    logic signed [ACC_W-1:0]   w_acc;
    logic signed [ACC_W-1:0]   w_sh;
    logic signed [ACC_W-1:0]   w_w_sat;
    logic signed [ACC_W-1:0]   w_y_sat;
    logic [TAP_BITS-1:0]       w_tap_m1;
    logic [DIW-1:0]            w_didx;
    logic [DELAY_BITS-1:0]     w_src;
    logic signed [HI_W-1:0]    w_src_hi;
    logic [SAMPLE_BITS-1:0]    w_mag;
    logic [63:0]               w_energy_sum;

    assign s_axis_tready = (w_ctl.state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_clear       = (s_axis_tuser != MODE_FILTER);
    assign w_emit_ok     = !r_out_vld || m_axis_tready;
    assign w_x           = s_axis_tdata[SAMPLE_BITS-1:0];

    afws_seq #(
        .TAPS (TAPS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_clear   (w_clear),
        .i_busy    (w_busy),
        .i_emit_ok (w_emit_ok),
        .o_ctl     (w_ctl)
    );

    // Magnitude of the filtered sample; the most negative value maps to 2^(N-1).
    assign w_mag = r_y[SAMPLE_BITS-1] ? ('0 - r_y) : r_y;

    // Operand selection for the shared multiplier.
    assign w_tap_m1 = w_ctl.tap - 1'b1;
    assign w_didx   = w_tap_m1[DIW-1:0];

    always_comb begin
        w_coef = '0;
        w_src  = r_delay[w_didx];
        unique case (w_ctl.state)
            S_FEED: begin
                w_coef = coef_den_neg(w_ctl.tap, COEF_FRAC_BITS);
            end
            S_OUT: begin
                w_coef = coef_num(w_ctl.tap, COEF_FRAC_BITS);
                if (w_ctl.tap == '0) begin
                    w_src = r_w0;
                end
            end
            S_SQ: begin
                w_coef = {{(COEF_W-SAMPLE_BITS){1'b0}}, w_mag};
                w_src  = {{(DELAY_BITS-SAMPLE_BITS){1'b0}}, w_mag};
            end
            default: begin
                w_coef = '0;
            end
        endcase
    end

    // The delay word goes through in two halves: signed upper, unsigned lower.
    assign w_src_hi = w_src[DELAY_BITS-1:LO_BITS];
    assign w_opnd   = w_ctl.hi ? OPND_W'(w_src_hi) : {1'b0, w_src[LO_BITS-1:0]};

    always_comb begin
        w_mac_ctl.issue = (w_ctl.state == S_FEED) || (w_ctl.state == S_OUT) ||
                          (w_ctl.state == S_SQ);
        w_mac_ctl.hi    = w_ctl.hi;
        w_mac_ctl.load  = (w_accept && !w_clear) || (w_ctl.state == S_W0) ||
                          (w_ctl.state == S_Y);
        w_mac_ctl.add   = ((w_ctl.state == S_FEED_RND) || (w_ctl.state == S_OUT_RND)) &&
                          !w_busy;
        priority if (w_ctl.state == S_IDLE) begin
            w_value = ACC_W'(w_x) <<< COEF_FRAC_BITS;
        end else if (w_mac_ctl.add) begin
            w_value = RND;
        end else begin
            w_value = '0;
        end
    end

    afws_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coef  (w_coef),
        .i_opnd  (w_opnd),
        .i_value (w_value),
        .o_acc   (w_acc),
        .o_busy  (w_busy)
    );

    // Rounded sum (rounding was added in the accumulator), then clamped.
    always_comb begin
        w_sh = w_acc >>> COEF_FRAC_BITS;
        if (w_sh > W_MAX) begin
            w_w_sat = W_MAX;
        end else if (w_sh < W_MIN) begin
            w_w_sat = W_MIN;
        end else begin
            w_w_sat = w_sh;
        end
        if (w_sh > Y_MAX) begin
            w_y_sat = Y_MAX;
        end else if (w_sh < Y_MIN) begin
            w_y_sat = Y_MIN;
        end else begin
            w_y_sat = w_sh;
        end
    end

    // The square is at most 2^62, so it sits in the low 63 bits of the sum.
    assign w_energy_sum = {1'b0, r_energy} + {1'b0, w_acc[62:0]};

    // Delay line and statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_delay[k] <= '0;
            end
            r_peak   <= '0;
            r_energy <= '0;
            r_count  <= '0;
        end else if (w_accept && w_clear) begin
            if (s_axis_tuser[1]) begin
                for (int k = 0; k < DEPTH; k++) begin
                    r_delay[k] <= '0;
                end
            end
            r_peak   <= '0;
            r_energy <= '0;
            r_count  <= '0;
        end else if (w_ctl.state == S_STATS) begin
            r_delay[0] <= r_w0;
            for (int k = 1; k < DEPTH; k++) begin
                r_delay[k] <= r_delay[k-1];
            end
            if (w_mag > r_peak) begin
                r_peak <= w_mag;
            end
            r_energy <= w_energy_sum[63] ? '1 : w_energy_sum[62:0];
            if (r_count != '1) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Intermediate results.
    always_ff @(posedge i_clk) begin
        if (w_ctl.state == S_W0) begin
            r_w0 <= w_w_sat[DELAY_BITS-1:0];
        end
        if (w_accept && w_clear) begin
            r_y <= '0;
        end else if (w_ctl.state == S_Y) begin
            r_y <= w_y_sat[SAMPLE_BITS-1:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((w_ctl.state == S_EMIT) && w_emit_ok) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_ctl.state == S_EMIT) && w_emit_ok) begin
            r_out_data <= {{PAD_W{1'b0}}, r_count, r_energy, r_peak, r_y};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    // The shared unit has drained whenever a new item can be taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_busy)
        else $error("multiplier pipeline busy while idle");

    // A result appears only after the sequencer reached its emit step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(w_ctl.state) == S_EMIT))
        else $error("result loaded outside the emit step");

    // Tap counter stays within the filter order; feedback never uses tap zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_ctl.state == S_FEED) || (w_ctl.state == S_OUT)) |->
        ((w_ctl.tap <= TAP_BITS'(TAPS-1)) &&
         ((w_ctl.state != S_FEED) || (w_ctl.tap != '0))))
        else $error("tap counter out of range");

    // With no sample counted, peak and energy must also be clear.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> ((r_peak == '0) && (r_energy == '0)))
        else $error("statistics inconsistent with sample count");
`endif

endmodule

>>> hdl/afws_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: split product, saturation to 64 bits and a
// saturating accumulator. Depends on afws_pkg.
module afws_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  afws_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [afws_pkg::COEF_W-1:0]  i_coef,
    input  logic signed [afws_pkg::OPND_W-1:0]  i_opnd,
    input  logic signed [afws_pkg::ACC_W-1:0]   i_value,
    output logic signed [afws_pkg::ACC_W-1:0]   o_acc,
    output logic                                o_busy
);
    import afws_pkg::*;

    logic                       r_m_vld;
    logic                       r_m_hi;
    logic signed [PROD_W-1:0]   r_m_prod;
    logic signed [PROD_W-1:0]   r_hi_prod;
    logic                       r_p_vld;
    logic signed [ACC_W-1:0]    r_p_val;
    logic signed [ACC_W-1:0]    r_acc;

    logic signed [PROD_W-1:0]   n_m_prod;
    logic signed [EXT_W-1:0]    w_exact;
    logic signed [ACC_W-1:0]    w_prod_sat;
    logic signed [ACC_W-1:0]    w_addend;
    logic signed [ACC_W:0]      w_sum;
    logic signed [ACC_W-1:0]    w_sum_sat;

    assign n_m_prod = i_coef * i_opnd;

    // The upper half arrives first and waits for the lower half.
    always_comb begin
        w_exact = (EXT_W'(r_hi_prod) <<< LO_BITS) + EXT_W'(r_m_prod);
        if ((w_exact[EXT_W-1:ACC_W-1] == '0) || (w_exact[EXT_W-1:ACC_W-1] == '1)) begin
            w_prod_sat = w_exact[ACC_W-1:0];
        end else begin
            w_prod_sat = w_exact[EXT_W-1] ? ACC_MIN : ACC_MAX;
        end
    end

    always_comb begin
        w_addend = i_ctl.add ? i_value : r_p_val;
        w_sum    = (ACC_W+1)'(r_acc) + (ACC_W+1)'(w_addend);
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_sum_sat = w_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            w_sum_sat = w_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_p_vld <= 1'b0;
        end else begin
            r_m_vld <= i_ctl.issue;
            r_p_vld <= r_m_vld && !r_m_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_hi   <= i_ctl.hi;
        r_m_prod <= n_m_prod;
        r_p_val  <= w_prod_sat;
        if (r_m_vld && r_m_hi) begin
            r_hi_prod <= r_m_prod;
        end
        priority if (i_ctl.load) begin
            r_acc <= i_value;
        end else if (i_ctl.add || r_p_vld) begin
            r_acc <= w_sum_sat;
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_m_vld | r_p_vld;

endmodule

>>> hdl/afws_seq.sv
`timescale 1ns / 1ps
// Sequencer of the filter: steps through the feedback taps, the output taps,
// the squaring and the statistics update. Depends on afws_pkg.
module afws_seq #(
    parameter int TAPS = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_clear,
    input  logic               i_busy,
    input  logic               i_emit_ok,
    output afws_pkg::t_seq_ctl o_ctl
);
    import afws_pkg::*;

    localparam logic [TAP_BITS-1:0] LAST_TAP = TAP_BITS'(TAPS - 1);

    t_state              r_state;
    t_state              n_state;
    logic [TAP_BITS-1:0] r_tap;
    logic [TAP_BITS-1:0] n_tap;
    logic                r_hi;
    logic                n_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_hi    <= 1'b1;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_hi    <= n_hi;
        end
    end

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        n_hi    = r_hi;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_clear) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_FEED;
                        n_tap   = TAP_BITS'(1);
                        n_hi    = 1'b1;
                    end
                end
            end
            S_FEED: begin
                if (r_hi) begin
                    n_hi = 1'b0;
                end else begin
                    n_hi = 1'b1;
                    if (r_tap == LAST_TAP) begin
                        n_state = S_FEED_RND;
                    end else begin
                        n_tap = r_tap + 1'b1;
                    end
                end
            end
            S_FEED_RND: begin
                if (!i_busy) begin
                    n_state = S_W0;
                end
            end
            S_W0: begin
                n_state = S_OUT;
                n_tap   = '0;
                n_hi    = 1'b1;
            end
            S_OUT: begin
                if (r_hi) begin
                    n_hi = 1'b0;
                end else begin
                    n_hi = 1'b1;
                    if (r_tap == LAST_TAP) begin
                        n_state = S_OUT_RND;
                    end else begin
                        n_tap = r_tap + 1'b1;
                    end
                end
            end
            S_OUT_RND: begin
                if (!i_busy) begin
                    n_state = S_Y;
                end
            end
            S_Y: begin
                n_state = S_SQ;
                n_hi    = 1'b1;
            end
            S_SQ: begin
                if (r_hi) begin
                    n_hi = 1'b0;
                end else begin
                    n_hi    = 1'b1;
                    n_state = S_SQ_WAIT;
                end
            end
            S_SQ_WAIT: begin
                if (!i_busy) begin
                    n_state = S_STATS;
                end
            end
            S_STATS: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_emit_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ctl = '{state: r_state, tap: r_tap, hi: r_hi};

endmodule

>>> tb/sv/a_weighting_filter_with_level_stats_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the A-weighting filter with level statistics.
// It drives sample and clearing items, predicts every result item in its own filter model
// and checks each one field by field. It depends on the RTL of the block only.
module a_weighting_filter_with_level_stats_tb;

    localparam int SMP_W   = 24;
    // The delay line carries sixteen integer bits above the sample width.
    localparam int LINE_W  = SMP_W + 16;
    localparam int FRAC    = 20;
    localparam int ORDER   = 6;
    localparam int SMP_MAX = 8388607;
    localparam int SMP_MIN = -8388608;

    localparam logic [1:0] MODE_FILTER      = 2'd0;
    localparam logic [1:0] MODE_CLR_STATS   = 2'd1;
    localparam logic [1:0] MODE_CLR_ALL     = 2'd2;
    localparam logic [1:0] MODE_CLR_ALL_ALT = 2'd3;

    // Handshake pressure phases, cycled every PHASE_LEN queued items.
    localparam logic [1:0] PH_FREE      = 2'd0;
    localparam logic [1:0] PH_SRC_IDLE  = 2'd1;
    localparam logic [1:0] PH_SNK_STALL = 2'd2;
    localparam logic [1:0] PH_BOTH      = 2'd3;
    localparam int PHASE_LEN = 75;

    localparam int DIRECTED_LEN = 25;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 400;
    // Drain time after the last expected result, so that any late stray result is still caught.
    localparam int DRAIN_CYCLES = 60;

    localparam logic signed [63:0] ACC_TOP    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_BOTTOM = 64'sh8000_0000_0000_0000;
    localparam logic [63:0]        ENERGY_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0]        COUNT_CAP  = 32'hFFFF_FFFF;

    // Filter coefficients in Q4.20: feed-forward (zeros) and feedback (poles).
    localparam longint FWD_COEF [0:ORDER] = '{
        245681, -491363, -245681, 982726, -245681, -491363, 245681
    };
    localparam longint FB_COEF [0:ORDER] = '{
        1048576, -4312846, 6871484, -5233357, 1872542, -258171, 11771
    };

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [SMP_W-1:0] sample;
        logic [1:0]              phase;
    } audio_item_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] filtered;
        logic [SMP_W-1:0]        peak;
        logic [62:0]             energy;
        logic [31:0]             count;
    } level_result_t;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // [23:0] sample.
    logic [SMP_W-1:0]         s_axis_tdata  = '0;
    // [1:0] mode.
    logic [1:0]               s_axis_tuser  = MODE_FILTER;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // [23:0] filtered, [47:24] peak_level, [110:48] energy_sum,
    // [142:111] sample_total, [143] padding.
    logic [143:0]             m_axis_tdata;

    a_weighting_filter_with_level_stats dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Items waiting to be offered, and results still owed by the block.
    audio_item_t   stim_q [$];
    level_result_t expected_q [$];

    // Predicted filter state: the direct form II delay line and the statistics.
    logic signed [63:0] wline [0:ORDER-1];
    logic [63:0]        peak_now   = '0;
    logic [63:0]        energy_now = '0;
    logic [31:0]        count_now  = '0;

    int n_queued    = 0;
    int n_clears    = 0;
    int n_accepted  = 0;
    int n_results   = 0;
    int n_saturated = 0;
    int n_errors    = 0;

    logic [1:0] cur_phase = PH_FREE;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    // Every product and every partial sum saturates at the 64-bit limits.
    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? ACC_BOTTOM : ACC_TOP;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] mul_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] p;
        wa = 128'(a);
        wb = 128'(b);
        p  = wa * wb;
        if (p[127:63] != {65{p[127]}}) return p[127] ? ACC_BOTTOM : ACC_TOP;
        return p[63:0];
    endfunction

    // Rounds half up by the coefficient fraction, then clips to a signed width.
    function automatic logic signed [63:0] round_clip(input logic signed [63:0] acc,
                                                      input int bits);
        logic signed [63:0] r;
        logic signed [63:0] top;
        r   = add_sat(acc, 64'sd1 <<< (FRAC - 1)) >>> FRAC;
        top = (64'sd1 <<< (bits - 1)) - 1;
        if (r > top) return top;
        if (r < -top - 1) return -top - 1;
        return r;
    endfunction

    // Advances the predicted filter by one item and returns the result it owes.
    function automatic level_result_t filter_step(input logic [1:0] mode,
                                                  input logic signed [SMP_W-1:0] sample);
        level_result_t      res;
        logic signed [63:0] acc;
        logic signed [63:0] w0;
        logic signed [63:0] y;
        logic [63:0]        mag;
        int                 i;
        res = '0;
        if (mode != MODE_FILTER) begin
            // Clearing items report zeros; the sample field is ignored.
            peak_now   = '0;
            energy_now = '0;
            count_now  = '0;
            if (mode == MODE_CLR_ALL || mode == MODE_CLR_ALL_ALT) begin
                for (i = 0; i < ORDER; i++) wline[i] = '0;
            end
            return res;
        end
        acc = 64'(sample);
        acc = acc <<< FRAC;
        for (i = 1; i <= ORDER; i++) begin
            acc = add_sat(acc, mul_sat(-FB_COEF[i], wline[i-1]));
        end
        w0  = round_clip(acc, LINE_W);
        acc = mul_sat(FWD_COEF[0], w0);
        for (i = 1; i <= ORDER; i++) begin
            acc = add_sat(acc, mul_sat(FWD_COEF[i], wline[i-1]));
        end
        y = round_clip(acc, SMP_W);
        for (i = ORDER - 1; i > 0; i--) wline[i] = wline[i-1];
        wline[0] = w0;

        // The most negative output gives a peak one above the positive maximum.
        mag = (y < 0) ? -y : y;
        if (mag > peak_now) peak_now = mag;
        energy_now = energy_now + mag * mag;
        if (energy_now > ENERGY_CAP) energy_now = ENERGY_CAP;
        if (count_now != COUNT_CAP) count_now = count_now + 1;

        res.filtered = y[SMP_W-1:0];
        res.peak     = peak_now[SMP_W-1:0];
        res.energy   = energy_now[62:0];
        res.count    = count_now;
        return res;
    endfunction

    // Queues one item; its handshake phase follows from its position in the run.
    task automatic queue_item(input logic [1:0] mode, input int sample);
        audio_item_t it;
        it.mode   = mode;
        it.sample = SMP_W'(sample);
        it.phase  = 2'((n_queued / PHASE_LEN) % 4);
        stim_q.push_back(it);
        n_queued++;
        if (mode != MODE_FILTER) n_clears++;
    endtask

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            n_errors++;
        end
    endtask

    // Sender side. The result of an item is predicted at the edge at which it is
    // accepted, so the predicted state always follows the order of acceptance.
    // A new item is offered only when the bus is free or the current item goes.
    audio_item_t on_bus;

    always @(posedge i_clk) begin : drive_items
        audio_item_t nxt;
        int          idle_pct;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_q.push_back(filter_step(on_bus.mode, on_bus.sample));
                n_accepted <= n_accepted + 1;
                cur_phase  <= on_bus.phase;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                idle_pct = 0;
                if (stim_q.size() != 0) begin
                    if (stim_q[0].phase == PH_SRC_IDLE) idle_pct = 75;
                    else if (stim_q[0].phase == PH_BOTH) idle_pct = 12;
                end
                if (stim_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    nxt           = stim_q.pop_front();
                    on_bus        <= nxt;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.sample;
                    s_axis_tuser  <= nxt.mode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once early in the run while the sender
    // keeps offering items, so that both the output register and the sequencer
    // fill and the block has to hold its input ready low.
    always @(posedge i_clk) begin : hold_off
        if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver side: compares each result with the oldest prediction and sets
    // the ready for the next cycle from the phase of the latest accepted item.
    always @(posedge i_clk) begin : check_results
        level_result_t want;
        level_result_t got;
        int            stall_pct;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.filtered = m_axis_tdata[23:0];
                got.peak     = m_axis_tdata[47:24];
                got.energy   = m_axis_tdata[110:48];
                got.count    = m_axis_tdata[142:111];
                n_results++;
                if (got.filtered == 24'h7F_FFFF || got.filtered == 24'h80_0000) begin
                    n_saturated++;
                end
                if (expected_q.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, m_axis_tdata);
                    n_errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("filtered", 64'(want.filtered), 64'(got.filtered));
                    check_field("peak_level", 64'(want.peak), 64'(got.peak));
                    check_field("energy_sum", 64'(want.energy), 64'(got.energy));
                    check_field("sample_total", 64'(want.count), 64'(got.count));
                end
            end
            stall_pct = 0;
            if (cur_phase == PH_SNK_STALL) stall_pct = 75;
            else if (cur_phase == PH_BOTH) stall_pct = 12;
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin : run
        int                      i;
        int                      k;
        int                      seg;
        int                      len;
        int                      period;
        int                      amp;
        logic signed [SMP_W-1:0] s;

        for (i = 0; i < ORDER; i++) wline[i] = '0;

        // Directed part: silence, both full-scale extremes and the smallest
        // values from reset, each kind of clearing item (including the unused
        // mode code, which must act as a full clear), then one cycle of a
        // full-scale square wave near 3 kHz, where the filter gain lifts the
        // output into saturation on both sides.
        queue_item(MODE_FILTER, 0);
        queue_item(MODE_FILTER, SMP_MAX);
        queue_item(MODE_FILTER, SMP_MIN);
        queue_item(MODE_FILTER, 1);
        queue_item(MODE_FILTER, -1);
        queue_item(MODE_CLR_STATS, $urandom);
        queue_item(MODE_FILTER, SMP_MAX);
        queue_item(MODE_CLR_ALL, SMP_MAX);
        queue_item(MODE_CLR_ALL_ALT, SMP_MIN);
        for (k = 0; k < 16; k++) queue_item(MODE_FILTER, (k < 8) ? SMP_MAX : SMP_MIN);

        // Random part, built from bursts so that the filter state travels far:
        // noise, tones of random period and level, impulses that ring down, and
        // the occasional clearing item.
        while (n_queued < DIRECTED_LEN + RANDOM_ITEMS) begin
            seg = $urandom_range(99);
            if (seg < 45) begin
                len = $urandom_range(40, 8);
                for (k = 0; k < len; k++) begin
                    case ($urandom_range(3))
                        0, 1: s = SMP_W'($urandom);
                        2: begin
                            s = SMP_W'($urandom);
                            s = s >>> $urandom_range(SMP_W - 1);
                        end
                        default: s = $urandom_range(1) ? SMP_MAX : SMP_MIN;
                    endcase
                    queue_item(MODE_FILTER, int'(s));
                end
            end else if (seg < 75) begin
                period = $urandom_range(40, 2);
                amp    = $urandom_range(1) ? SMP_MAX : $urandom_range(SMP_MAX);
                len    = $urandom_range(64, 16);
                for (k = 0; k < len; k++) begin
                    queue_item(MODE_FILTER, ((k % period) < period / 2) ? amp : -amp - 1);
                end
            end else if (seg < 85) begin
                queue_item(MODE_FILTER, $urandom);
                len = $urandom_range(30, 10);
                for (k = 0; k < len; k++) queue_item(MODE_FILTER, 0);
            end else begin
                queue_item(2'($urandom_range(MODE_CLR_ALL_ALT, MODE_CLR_STATS)), $urandom);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items (%0d clearing) under four handshake phases",
                 n_accepted, n_clears);
        $display("and a %0d-cycle output hold-off; %0d results checked, %0d saturated.",
                 HOLD_CYCLES, n_results, n_saturated);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Ends the run with a failure if it hangs; the limit lies far beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("%0t: timeout with %0d results still owed", $time, expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> a_weighting_filter_with_level_stats.f
hdl/afws_pkg.sv
hdl/afws_mac.sv
hdl/afws_seq.sv
hdl/a_weighting_filter_with_level_stats.sv
tb/sv/a_weighting_filter_with_level_stats_tb.sv
